FILE: sv/bptd_pkg.sv
// Shared types, codes and helper functions for the binary period task dispatcher.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package bptd_pkg;

   localparam int DataWidth  = 16;
   localparam int IdWidth    = 4;
   localparam int KindWidth  = 2;
   localparam int StatWidth  = 2;
   localparam int TaskSlots  = 16;
   localparam int SlotLimit  = 16;

   typedef enum logic [KindWidth-1:0] {
      KIND_TICK   = 2'd0,
      KIND_SET    = 2'd1,
      KIND_CANCEL = 2'd2,
      KIND_START  = 2'd3
   } kind_type;

   typedef enum logic [StatWidth-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_PERIOD = 2'd1,
      STATUS_NOT_SET    = 2'd2
   } status_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

   // index of the lowest set bit; zero for a zero word
   function automatic logic [IdWidth-1:0] low_bit_index(input logic [DataWidth-1:0] v);
      logic [IdWidth-1:0] n;
      n = '0;
      for (int i = DataWidth - 1; i >= 0; i--) begin
         if (v[i]) begin
            n = IdWidth'(i);
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: sv/bptd_ifs.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on bptd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bptd_req_if;
   import bptd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KindWidth-1:0] kind;
   logic [IdWidth-1:0]   task_id;
   logic [DataWidth-1:0] period;

   modport source (output valid, output kind, output task_id, output period, input ready);
   modport sink   (input valid, input kind, input task_id, input period, output ready);
endinterface

interface bptd_rsp_if;
   import bptd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [DataWidth-1:0] activate_mask;
   logic [IdWidth-1:0]   fired_slot;
   logic                 suspend_valid;
   logic [IdWidth-1:0]   suspend_task;
   logic [StatWidth-1:0] status;

   modport source (output valid, output activate_mask, output fired_slot,
                   output suspend_valid, output suspend_task, output status, input ready);
   modport sink   (input valid, input activate_mask, input fired_slot,
                   input suspend_valid, input suspend_task, input status, output ready);
endinterface

`default_nettype wire

FILE: sv/bptd_ctrl.sv
// Controller state machine: sequences capture, execute and response hand-off.
// Depends on bptd_pkg for the command struct.
`timescale 1ns / 1ps
`default_nettype none

module bptd_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output bptd_pkg::cmd_type  cmd
);
   import bptd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready   = (state_ff == ST_IDLE) || ((state_ff == ST_RESP) && rsp_ready);
   assign accept      = req_valid && req_ready;
   assign cmd.capture = accept;
   assign cmd.execute = (state_ff == ST_EXEC);
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_RESP;
            rsp_valid_in = 1'b1;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = accept ? ST_EXEC : ST_IDLE;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      accept |=> cmd.execute)
      else $error("accepted transaction not executed");

   a_exec_presents: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> (rsp_valid && !cmd.execute))
      else $error("executed transaction not presented");

   a_no_exec_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.execute && rsp_valid))
      else $error("execute while response pending");

endmodule

`default_nettype wire

FILE: sv/bptd_datapath.sv
// Datapath: tick counter, slot task masks, per-task slot records and result registers.
// Depends on bptd_pkg; driven by bptd_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module bptd_datapath #(
   parameter int SLOT_COUNT = 16,
   parameter int TASK_COUNT = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  bptd_pkg::cmd_type                   cmd,
   input  wire  [bptd_pkg::KindWidth-1:0]      req_kind,
   input  wire  [bptd_pkg::IdWidth-1:0]        req_task_id,
   input  wire  [bptd_pkg::DataWidth-1:0]      req_period,
   input  wire                                 csr_we,
   input  wire  [bptd_pkg::DataWidth-1:0]      csr_wdata,
   output logic [bptd_pkg::DataWidth-1:0]      rsp_activate_mask,
   output logic [bptd_pkg::IdWidth-1:0]        rsp_fired_slot,
   output logic                                rsp_suspend_valid,
   output logic [bptd_pkg::IdWidth-1:0]        rsp_suspend_task,
   output logic [bptd_pkg::StatWidth-1:0]      rsp_status
);
   import bptd_pkg::*;

   localparam int SlotDepth = (SLOT_COUNT < SlotLimit) ? SLOT_COUNT : SlotLimit;
   localparam int TaskDepth = (TASK_COUNT < TaskSlots) ? TASK_COUNT : TaskSlots;

   logic [KindWidth-1:0] kind_ff;
   logic [IdWidth-1:0]   tid_ff;
   logic [DataWidth-1:0] period_ff;

   logic [DataWidth-1:0] alarm_ff;
   logic [DataWidth-1:0] counter_ff, counter_in;
   logic [DataWidth-1:0] masks_ff [SlotDepth];
   logic [DataWidth-1:0] masks_in [SlotDepth];
   logic [IdWidth-1:0]   slot_ff  [TaskDepth];
   logic [IdWidth-1:0]   slot_in  [TaskDepth];
   logic [TaskDepth-1:0] has_ff, has_in;

   logic [DataWidth-1:0] act_ff, act_in;
   logic [IdWidth-1:0]   fired_ff, fired_in;
   logic                 sv_ff, sv_in;
   logic [IdWidth-1:0]   st_ff, st_in;
   logic [StatWidth-1:0] status_ff, status_in;

   logic [DataWidth-1:0] sum;
   logic [DataWidth-1:0] tid_bit;
   logic [IdWidth-1:0]   sum_slot;
   logic [IdWidth-1:0]   period_slot;
   logic [IdWidth-1:0]   old_slot;
   logic                 period_ok;
   logic                 tid_ok;

   assign sum         = counter_ff + alarm_ff;
   assign sum_slot    = low_bit_index(sum);
   assign period_slot = low_bit_index(period_ff);
   assign period_ok   = (period_ff != '0) && ((period_ff & (period_ff - 16'd1)) == '0);
   assign tid_ok      = int'(tid_ff) < TaskDepth;
   assign tid_bit     = DataWidth'(1) << tid_ff;

   always_comb begin
      counter_in = counter_ff;
      masks_in   = masks_ff;
      slot_in    = slot_ff;
      has_in     = has_ff;
      act_in     = '0;
      fired_in   = '0;
      sv_in      = 1'b0;
      st_in      = '0;
      status_in  = STATUS_OK;
      old_slot   = '0;
      case (kind_ff)
         KIND_TICK: begin
            counter_in = sum;
            if (sum != '0) begin
               fired_in = sum_slot;
               if (int'(sum_slot) < SlotDepth) begin
                  act_in = masks_ff[sum_slot];
               end
            end
         end
         KIND_SET: begin
            if (!period_ok || int'(period_slot) >= SlotDepth) begin
               status_in = STATUS_BAD_PERIOD;
            end else if (tid_ok) begin
               masks_in[period_slot] = masks_ff[period_slot] | tid_bit;
               slot_in[tid_ff]       = period_slot;
               has_in[tid_ff]        = 1'b1;
            end
         end
         KIND_CANCEL: begin
            if (tid_ok && has_ff[tid_ff]) begin
               old_slot = slot_ff[tid_ff];
               if (int'(old_slot) < SlotDepth) begin
                  masks_in[old_slot] = masks_ff[old_slot] & ~tid_bit;
               end
               sv_in = 1'b1;
               st_in = tid_ff;
            end else begin
               status_in = STATUS_NOT_SET;
            end
         end
         KIND_START: begin
            counter_in = counter_ff & ~(alarm_ff - 16'd1);
         end
         default: begin
            counter_in = counter_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_kind;
         tid_ff    <= req_task_id;
         period_ff <= req_period;
      end
      if (cmd.execute) begin
         act_ff    <= act_in;
         fired_ff  <= fired_in;
         sv_ff     <= sv_in;
         st_ff     <= st_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_ff   <= 16'd1;
         counter_ff <= '0;
         has_ff     <= '0;
         for (int i = 0; i < SlotDepth; i++) begin
            masks_ff[i] <= '0;
         end
         for (int i = 0; i < TaskDepth; i++) begin
            slot_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            alarm_ff <= csr_wdata;
         end
         if (cmd.execute) begin
            counter_ff <= counter_in;
            masks_ff   <= masks_in;
            slot_ff    <= slot_in;
            has_ff     <= has_in;
         end
      end
   end

   assign rsp_activate_mask = act_ff;
   assign rsp_fired_slot    = fired_ff;
   assign rsp_suspend_valid = sv_ff;
   assign rsp_suspend_task  = st_ff;
   assign rsp_status        = status_ff;

   a_tick_advance: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && kind_ff == KIND_TICK) |=> (counter_ff == $past(sum)))
      else $error("tick counter did not advance by alarm cycle");

   a_start_aligns: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && kind_ff == KIND_START && !csr_we)
         |=> ((counter_ff & (alarm_ff - 16'd1)) == '0))
      else $error("start left counter bits below alarm cycle");

   a_suspend_ok: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && sv_in) |=> (sv_ff && status_ff == STATUS_OK && act_ff == '0))
      else $error("suspend request with error status or mask");

endmodule

`default_nettype wire

FILE: sv/binary_period_task_dispatcher.sv
// Binary period task dispatcher, top level: wires controller, datapath and channels.
// Depends on bptd_pkg, bptd_ifs, bptd_ctrl and bptd_datapath.
//
// Usage:
//   req_bus carries one transaction per item: kind (tick, set alarm, cancel alarm,
//   start), task_id and period. rsp_bus returns exactly one transaction per item:
//   activate_mask, fired_slot, suspend_valid, suspend_task and status.
//   csr_we/csr_wdata write alarm_cycle; write only while no item is in flight.
// Timing:
//   An accepted item executes in the next cycle and its response turns valid at the
//   edge that ends that cycle. One item is in flight at a time; a new item is
//   accepted in the same cycle the pending response is taken, so the next item can
//   enter while the last response is handed off. The single execute step (counter
//   add, lowest-bit encode, slot mask read-modify-write) computes each item's result.
// Reset:
//   Synchronous, active high: alarm_cycle = 1, counter, slot masks, task slots
//   and period flags cleared; no response pending.
// Stall:
//   While a response is pending and rsp_bus.ready is low, the response holds and req_bus.ready stays low.
`timescale 1ns / 1ps
`default_nettype none

module binary_period_task_dispatcher #(
   parameter int SLOT_COUNT = 16,
   parameter int TASK_COUNT = 16
) (
   input  wire                             clock,
   input  wire                             reset,
   bptd_req_if.sink                        req_bus,
   bptd_rsp_if.source                      rsp_bus,
   input  wire                             csr_we,
   input  wire  [bptd_pkg::DataWidth-1:0]  csr_wdata
);
   import bptd_pkg::*;

   cmd_type cmd;

   bptd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   bptd_datapath #(
      .SLOT_COUNT (SLOT_COUNT),
      .TASK_COUNT (TASK_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_kind          (req_bus.kind),
      .req_task_id       (req_bus.task_id),
      .req_period        (req_bus.period),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_activate_mask (rsp_bus.activate_mask),
      .rsp_fired_slot    (rsp_bus.fired_slot),
      .rsp_suspend_valid (rsp_bus.suspend_valid),
      .rsp_suspend_task  (rsp_bus.suspend_task),
      .rsp_status        (rsp_bus.status)
   );

endmodule

`default_nettype wire

FILE: sim/tb_binary_period_task_dispatcher.sv
// Testbench for binary_period_task_dispatcher: directed and random transactions,
// checked against an in-bench scheduler predictor with valid/ready stalls on both sides.
// Depends on bptd_pkg, bptd_ifs and the dispatcher RTL.
`timescale 1ns / 1ps

module tb_binary_period_task_dispatcher;
   import bptd_pkg::*;

   localparam int CycleLimit  = 400000;
   localparam int PhaseCount  = 10;
   localparam int PhaseItems  = 115;
   localparam int PrintLimit  = 200;

   typedef struct packed {
      kind_type             kind;
      logic [IdWidth-1:0]   task_id;
      logic [DataWidth-1:0] period;
   } dispatch_item_type;

   typedef struct packed {
      logic [DataWidth-1:0] activate_mask;
      logic [IdWidth-1:0]   fired_slot;
      logic                 suspend_valid;
      logic [IdWidth-1:0]   suspend_task;
      status_type           status;
   } dispatch_result_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [DataWidth-1:0] csr_wdata;
   logic                 quiet = 1'b0;
   int                   error_count = 0;
   int                   cycle_count = 0;

   bptd_req_if req_bus();
   bptd_rsp_if rsp_bus();

   // scheduler state as the predictor sees it
   logic [DataWidth-1:0] cycle_step;
   logic [DataWidth-1:0] tick_count;
   logic [DataWidth-1:0] slot_masks [TaskSlots];
   logic [IdWidth-1:0]   task_slot_of [TaskSlots];
   logic                 task_armed [TaskSlots];

   dispatch_result_type expected_q[$];

   binary_period_task_dispatcher uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int lowest_one(input logic [DataWidth-1:0] v);
      for (int i = 0; i < DataWidth; i++) begin
         if (v[i]) begin
            return i;
         end
      end
      return 0;
   endfunction

   function automatic dispatch_result_type dispatch_predict(input dispatch_item_type it);
      dispatch_result_type  r;
      int                   slot;
      logic [DataWidth-1:0] low_mask;
      logic [DataWidth-1:0] below;
      r = '0;
      r.status = STATUS_OK;
      case (it.kind)
         KIND_TICK: begin
            tick_count = tick_count + cycle_step;
            if (tick_count != '0) begin
               slot = lowest_one(tick_count);
               r.fired_slot = IdWidth'(slot);
               r.activate_mask = slot_masks[slot];
            end
         end
         KIND_SET: begin
            below = it.period - 16'd1;
            if (it.period == '0 || (it.period & below) != '0) begin
               r.status = STATUS_BAD_PERIOD;
            end else begin
               slot = lowest_one(it.period);
               slot_masks[slot][it.task_id] = 1'b1;
               task_slot_of[it.task_id] = IdWidth'(slot);
               task_armed[it.task_id] = 1'b1;
            end
         end
         KIND_CANCEL: begin
            if (task_armed[it.task_id]) begin
               slot_masks[task_slot_of[it.task_id]][it.task_id] = 1'b0;
               r.suspend_valid = 1'b1;
               r.suspend_task = it.task_id;
            end else begin
               r.status = STATUS_NOT_SET;
            end
         end
         default: begin
            low_mask = cycle_step - 16'd1;
            tick_count = tick_count & ~low_mask;
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= PrintLimit) begin
         $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what,
                  got, want);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      dispatch_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected transaction", 32'(rsp_bus.status), 32'd0);
         end else begin
            want = expected_q.pop_front();
            if (rsp_bus.activate_mask !== want.activate_mask)
               report_mismatch("activate_mask", 32'(rsp_bus.activate_mask),
                               32'(want.activate_mask));
            if (rsp_bus.fired_slot !== want.fired_slot)
               report_mismatch("fired_slot", 32'(rsp_bus.fired_slot), 32'(want.fired_slot));
            if (rsp_bus.suspend_valid !== want.suspend_valid)
               report_mismatch("suspend_valid", 32'(rsp_bus.suspend_valid),
                               32'(want.suspend_valid));
            if (rsp_bus.suspend_task !== want.suspend_task)
               report_mismatch("suspend_task", 32'(rsp_bus.suspend_task),
                               32'(want.suspend_task));
            if (rsp_bus.status !== want.status)
               report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
         end
      end
   end

   // response back-pressure in bursts
   initial begin
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(20, 60)) @(posedge clock);
            end
         end
      end
   end

   task automatic send_item(input kind_type k, input logic [IdWidth-1:0] id,
                            input logic [DataWidth-1:0] p);
      dispatch_item_type it;
      it.kind = k;
      it.task_id = id;
      it.period = p;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.kind    <= k;
      req_bus.task_id <= id;
      req_bus.period  <= p;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_q.push_back(dispatch_predict(it));
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_alarm_cycle(input logic [DataWidth-1:0] v);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      cycle_step = v;
   endtask

   task automatic test_set_and_fire();
      send_item(KIND_SET, 4'd0, 16'h0001);
      send_item(KIND_SET, 4'd15, 16'h8000);
      send_item(KIND_SET, 4'd3, 16'h0002);
      send_item(KIND_TICK, 4'd0, 16'h0000);
      send_item(KIND_TICK, 4'd0, 16'h0000);
      send_item(KIND_TICK, 4'd0, 16'h0000);
   endtask

   task automatic test_bad_period();
      send_item(KIND_SET, 4'd7, 16'h0000);
      send_item(KIND_SET, 4'd7, 16'h0003);
      send_item(KIND_SET, 4'd7, 16'hFFFF);
   endtask

   task automatic test_cancel();
      send_item(KIND_CANCEL, 4'd5, 16'h0000);
      // re-arm keeps the old slot bit
      send_item(KIND_SET, 4'd3, 16'h0004);
      send_item(KIND_CANCEL, 4'd3, 16'h0000);
      send_item(KIND_CANCEL, 4'd3, 16'h0000);
      send_item(KIND_TICK, 4'd0, 16'h0000);
      send_item(KIND_START, 4'd0, 16'h0000);
   endtask

   task automatic test_cycle_extremes();
      write_alarm_cycle(16'h8000);
      send_item(KIND_START, 4'd0, 16'h0000);
      send_item(KIND_TICK, 4'd0, 16'h0000);
      send_item(KIND_TICK, 4'd0, 16'h0000);
      send_item(KIND_TICK, 4'd0, 16'h0000);
      write_alarm_cycle(16'h0000);
      send_item(KIND_START, 4'd0, 16'h0000);
      send_item(KIND_TICK, 4'd0, 16'h0000);
      write_alarm_cycle(16'hFFFF);
      send_item(KIND_START, 4'd0, 16'h0000);
      send_item(KIND_TICK, 4'd0, 16'h0000);
   endtask

   task automatic test_random_traffic();
      logic [DataWidth-1:0] phase_cycle [PhaseCount];
      int                   armed[$];
      int                   pick;
      logic [IdWidth-1:0]   id;
      logic [DataWidth-1:0] p;
      phase_cycle = '{16'h0001, 16'h0002, 16'h8000, 16'h0000, 16'h0003, 16'hFFFF,
                      16'h0001 << $urandom_range(0, 15), 16'($urandom),
                      16'h0004, 16'h0001};
      for (int ph = 0; ph < PhaseCount; ph++) begin
         write_alarm_cycle(phase_cycle[ph]);
         if (ph == PhaseCount - 1) begin
            quiet = 1'b1;
         end
         for (int n = 0; n < PhaseItems; n++) begin
            pick = $urandom_range(0, 99);
            id = IdWidth'($urandom_range(0, 15));
            p = 16'($urandom);
            if (pick < 40) begin
               send_item(KIND_TICK, id, p);
            end else if (pick < 70) begin
               pick = $urandom_range(0, 99);
               if (pick < 60) begin
                  p = 16'h0001 << $urandom_range(0, 5);
               end else if (pick < 80) begin
                  p = 16'h0001 << $urandom_range(0, 15);
               end else if (pick < 85) begin
                  p = 16'h0000;
               end else if (pick < 88) begin
                  p = 16'hFFFF;
               end
               send_item(KIND_SET, id, p);
            end else if (pick < 85) begin
               armed.delete();
               for (int t = 0; t < TaskSlots; t++) begin
                  if (task_armed[t]) begin
                     armed.push_back(t);
                  end
               end
               if (armed.size() != 0 && $urandom_range(0, 9) < 7) begin
                  id = IdWidth'(armed[$urandom_range(0, armed.size() - 1)]);
               end
               send_item(KIND_CANCEL, id, p);
            end else begin
               send_item(KIND_START, id, p);
            end
         end
      end
   endtask

   initial begin
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_wdata       <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.kind    <= KIND_TICK;
      req_bus.task_id <= '0;
      req_bus.period  <= '0;
      cycle_step = 16'h0001;
      tick_count = '0;
      for (int t = 0; t < TaskSlots; t++) begin
         slot_masks[t]   = '0;
         task_slot_of[t] = '0;
         task_armed[t]   = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_set_and_fire();
      test_bad_period();
      test_cancel();
      test_cycle_extremes();
      test_random_traffic();

      wait_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
